>>> sv/ims_pkg.sv
package ims_pkg;

	localparam int MAX_RESULTS = 32;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_LIST = 1'b1;

	typedef enum logic [2:0] {
		ST_ADDED      = 3'd0,
		ST_IGNORED    = 3'd1,
		ST_REJECTED   = 3'd2,
		ST_LIST_ENTRY = 3'd3,
		ST_LIST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_MOVE,
		S_MV_RD,
		S_MV_WR,
		S_MERGE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    scan;
		logic    init_move;
		logic    mv_rd;
		logic    mv_wr;
		logic    wr_merge;
		logic    emit;
		status_t emit_st;
	} ctrl_t;

	typedef struct packed {
		logic n_zero;
		logic empty_in;
		logic scan_done;
		logic full_reject;
		logic move_more;
	} stat_t;

endpackage

>>> sv/ims_ctrl.sv
module ims_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          cmd,
	input  ims_pkg::stat_t st,
	output ims_pkg::ctrl_t ctl,
	output logic          busy
);

	ims_pkg::state_t state_q, state_d;
	logic cmd_list_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ims_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.emit_st = ims_pkg::ST_ADDED;
		case (state_q)
			ims_pkg::S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					if (cmd == ims_pkg::CMD_LIST) begin
						if (st.n_zero) begin
							ctl.emit = 1'b1;
							ctl.emit_st = ims_pkg::ST_LIST_EMPTY;
						end else begin
							state_d = ims_pkg::S_SCAN;
						end
					end else if (st.empty_in) begin
						ctl.emit = 1'b1;
						ctl.emit_st = ims_pkg::ST_IGNORED;
					end else begin
						state_d = ims_pkg::S_SCAN;
					end
				end
			end
			ims_pkg::S_SCAN: begin
				ctl.scan = 1'b1;
				if (st.scan_done) begin
					state_d = (cmd_list_q) ? ims_pkg::S_IDLE : ims_pkg::S_DECIDE;
				end
			end
			ims_pkg::S_DECIDE: begin
				if (st.full_reject) begin
					ctl.emit = 1'b1;
					ctl.emit_st = ims_pkg::ST_REJECTED;
					state_d = ims_pkg::S_IDLE;
				end else begin
					ctl.init_move = 1'b1;
					state_d = ims_pkg::S_MOVE;
				end
			end
			ims_pkg::S_MOVE: begin
				state_d = st.move_more ? ims_pkg::S_MV_RD : ims_pkg::S_MERGE;
			end
			ims_pkg::S_MV_RD: begin
				ctl.mv_rd = 1'b1;
				state_d = ims_pkg::S_MV_WR;
			end
			ims_pkg::S_MV_WR: begin
				ctl.mv_wr = 1'b1;
				state_d = ims_pkg::S_MOVE;
			end
			ims_pkg::S_MERGE: begin
				ctl.wr_merge = 1'b1;
				state_d = ims_pkg::S_IDLE;
			end
			default: begin
				state_d = ims_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_list_q <= 1'b0;
		end else if (ctl.load) begin
			cmd_list_q <= (cmd == ims_pkg::CMD_LIST);
		end
	end

	assign busy = (state_q != ims_pkg::S_IDLE);

endmodule

>>> sv/ims_dp.sv
module ims_dp #(
	parameter int CAPACITY   = 32,
	parameter int COORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd,
	input  logic [31:0]   lo,
	input  logic [31:0]   hi,
	input  ims_pkg::ctrl_t ctl,
	output ims_pkg::stat_t st,
	output logic          valid,
	output logic [2:0]    status,
	output logic [31:0]   start_res,
	output logic [31:0]   finish,
	output logic [5:0]    entries,
	output logic          last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	logic [COORD_BITS-1:0] mem_s [CAPACITY];
	logic [COORD_BITS-1:0] mem_e [CAPACITY];

	logic [COORD_BITS-1:0] lo_c, hi_c, lo_q, hi_q, ms_q, me_q, rd_s_q, rd_e_q, ws, we_d;
	logic [CNT_W-1:0] n_q, idx_q, before_q, absorbed_q, j_q, limit, shown, d, new_n;
	logic [IDX_W-1:0] raddr, waddr;
	logic cmd_q, right_q, rv_q, rd_en, wr_en;

	assign lo_c = COORD_BITS'(lo);
	assign hi_c = COORD_BITS'(hi);

	assign shown = (32'(n_q) < ims_pkg::MAX_RESULTS) ? n_q : CNT_W'(ims_pkg::MAX_RESULTS);
	assign limit = (cmd_q == ims_pkg::CMD_LIST) ? shown : n_q;
	assign d     = absorbed_q - CNT_W'(1);
	assign new_n = n_q - absorbed_q + CNT_W'(1);

	assign st.n_zero      = (n_q == '0);
	assign st.empty_in    = (lo_c >= hi_c);
	assign st.scan_done   = (idx_q == limit) && !rv_q;
	assign st.full_reject = (absorbed_q == '0) && (n_q >= CNT_W'(CAPACITY));
	assign st.move_more   = right_q ? (j_q > before_q) : ((d != '0) && (j_q < n_q));

	assign rd_en = (ctl.scan && (idx_q < limit)) || ctl.mv_rd;
	assign wr_en = ctl.mv_wr || ctl.wr_merge;

	always_comb begin
		if (ctl.scan) begin
			raddr = idx_q[IDX_W-1:0];
		end else if (right_q) begin
			raddr = IDX_W'(j_q - CNT_W'(1));
		end else begin
			raddr = j_q[IDX_W-1:0];
		end
		if (ctl.wr_merge) begin
			waddr = before_q[IDX_W-1:0];
			ws    = ms_q;
			we_d  = me_q;
		end else begin
			waddr = right_q ? j_q[IDX_W-1:0] : IDX_W'(j_q - d);
			ws    = rd_s_q;
			we_d  = rd_e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s_q <= mem_s[raddr];
			rd_e_q <= mem_e[raddr];
		end
		if (wr_en) begin
			mem_s[waddr] <= ws;
			mem_e[waddr] <= we_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			rv_q  <= 1'b0;
			valid <= 1'b0;
		end else begin
			rv_q  <= ctl.scan && (idx_q < limit);
			valid <= ctl.emit || ctl.wr_merge || (rv_q && cmd_q == ims_pkg::CMD_LIST);
			if (ctl.wr_merge) begin
				n_q <= new_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= cmd;
			lo_q       <= lo_c;
			hi_q       <= hi_c;
			ms_q       <= lo_c;
			me_q       <= hi_c;
			idx_q      <= '0;
			before_q   <= '0;
			absorbed_q <= '0;
		end else begin
			if (ctl.scan && (idx_q < limit)) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (rv_q && cmd_q == ims_pkg::CMD_ADD) begin
				if (rd_e_q < lo_q) begin
					before_q <= before_q + CNT_W'(1);
				end else if (rd_s_q <= hi_q) begin
					absorbed_q <= absorbed_q + CNT_W'(1);
					if (rd_s_q < ms_q) ms_q <= rd_s_q;
					if (rd_e_q > me_q) me_q <= rd_e_q;
				end
			end
		end
		if (ctl.init_move) begin
			right_q <= (absorbed_q == '0);
			j_q     <= (absorbed_q == '0) ? n_q : before_q + absorbed_q;
		end else if (ctl.mv_wr) begin
			j_q <= right_q ? j_q - CNT_W'(1) : j_q + CNT_W'(1);
		end

		if (ctl.wr_merge) begin
			status    <= ims_pkg::ST_ADDED;
			start_res <= 32'(ms_q);
			finish    <= 32'(me_q);
			entries   <= 6'(new_n);
			last      <= 1'b1;
		end else if (ctl.emit) begin
			status  <= ctl.emit_st;
			last    <= 1'b1;
			entries <= 6'(n_q);
			case (ctl.emit_st)
				ims_pkg::ST_IGNORED: begin
					start_res <= 32'(lo_c);
					finish    <= 32'(hi_c);
				end
				ims_pkg::ST_REJECTED: begin
					start_res <= 32'(lo_q);
					finish    <= 32'(hi_q);
				end
				default: begin
					start_res <= '0;
					finish    <= '0;
				end
			endcase
		end else if (rv_q) begin
			status    <= ims_pkg::ST_LIST_ENTRY;
			start_res <= 32'(rd_s_q);
			finish    <= 32'(rd_e_q);
			entries   <= 6'(n_q);
			last      <= (idx_q == shown);
		end
	end

endmodule

>>> sv/interval_merge_set.sv
// Sorted set of disjoint half-open intervals with merge on add.
// Command channel: a beat (cmd, lo, hi) is taken on a rising edge with
// start high and busy low. cmd add merges [lo,hi) with every stored
// interval it overlaps or touches; cmd list streams the table in order.
// Result channel: each result beat is on status/start_res/finish/entries/
// last for exactly one cycle, flagged by valid; last marks the final beat
// of a command. There is no back-pressure on results.
// Sequencing: an empty add or a list of an empty table answers in the
// cycle after acceptance and keeps busy low. An add scans the n stored
// entries through the single registered read port, then decides, moves
// each entry above the merge point through MOVE, MV_RD and MV_WR, ends
// the move in MOVE and writes the merged interval in MERGE; the result
// beat comes as busy falls. A rejected add ends after scan and decision.
// A list reads the first min(n, MAX_RESULTS) entries and gives one beat
// per cycle, the last in the final busy cycle.
// Reset clears the entry count and the controller; table contents need no
// clearing as only entries below the count are read.
module interval_merge_set #(
	parameter int CAPACITY   = 32,
	parameter int COORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [31:0] lo,
	input  logic [31:0] hi,
	output logic        valid,
	output logic [2:0]  status,
	output logic [31:0] start_res,
	output logic [31:0] finish,
	output logic [5:0]  entries,
	output logic        last
);

	ims_pkg::ctrl_t ctl;
	ims_pkg::stat_t st;

	ims_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	ims_dp #(
		.CAPACITY   (CAPACITY),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.lo        (lo),
		.hi        (hi),
		.ctl       (ctl),
		.st        (st),
		.valid     (valid),
		.status    (status),
		.start_res (start_res),
		.finish    (finish),
		.entries   (entries),
		.last      (last)
	);

endmodule

>>> test/ims_checker.sv
module ims_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        cmd,
	input  logic [31:0] lo,
	input  logic [31:0] hi,
	input  logic        valid,
	input  logic [2:0]  status,
	input  logic [31:0] start_res,
	input  logic [31:0] finish,
	input  logic [5:0]  entries,
	input  logic        last,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 32;

	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] s;
		logic [31:0] e;
		logic [5:0]  n;
		logic        l;
	} beat_t;

	logic [31:0] tbl_s [CAP];
	logic [31:0] tbl_e [CAP];
	int          tbl_n;
	beat_t       want_q [$];

	task automatic push(input logic [2:0] st, input logic [31:0] s, input logic [31:0] e,
			input int n, input logic l);
		beat_t b;
		b.st = st; b.s = s; b.e = e; b.n = n[5:0]; b.l = l;
		want_q.insert(want_q.size(), b);
	endtask

	task automatic predict_cmd(input logic c, input logic [31:0] a, input logic [31:0] z);
		logic [31:0] ms, me;
		logic [31:0] ns [CAP];
		logic [31:0] ne [CAP];
		int below, absorbed, m, i;
		if (c == ims_pkg::CMD_LIST) begin
			if (tbl_n == 0) push(ims_pkg::ST_LIST_EMPTY, 0, 0, 0, 1'b1);
			else
				for (i = 0; i < tbl_n && i < ims_pkg::MAX_RESULTS; i++)
					push(ims_pkg::ST_LIST_ENTRY, tbl_s[i], tbl_e[i], tbl_n,
						i + 1 == tbl_n || i + 1 == ims_pkg::MAX_RESULTS);
			return;
		end
		if (a >= z) begin
			push(ims_pkg::ST_IGNORED, a, z, tbl_n, 1'b1);
			return;
		end
		ms = a; me = z; below = 0; absorbed = 0;
		for (i = 0; i < tbl_n; i++) begin
			if (tbl_e[i] < a) below++;
			else if (tbl_s[i] <= z) begin
				absorbed++;
				if (tbl_s[i] < ms) ms = tbl_s[i];
				if (tbl_e[i] > me) me = tbl_e[i];
			end
		end
		if (absorbed == 0 && tbl_n >= CAP) begin
			push(ims_pkg::ST_REJECTED, a, z, tbl_n, 1'b1);
			return;
		end
		m = 0;
		for (i = 0; i < below; i++) begin
			ns[m] = tbl_s[i]; ne[m] = tbl_e[i]; m++;
		end
		ns[m] = ms; ne[m] = me; m++;
		for (i = below + absorbed; i < tbl_n && m < CAP; i++) begin
			ns[m] = tbl_s[i]; ne[m] = tbl_e[i]; m++;
		end
		for (i = 0; i < m; i++) begin
			tbl_s[i] = ns[i]; tbl_e[i] = ne[i];
		end
		tbl_n = m;
		push(ims_pkg::ST_ADDED, ms, me, m, 1'b1);
	endtask

	assign pending = want_q.size();

	always @(posedge clk or negedge arst_n) begin
		beat_t w;
		if (!arst_n) begin
			tbl_n = 0;
			fail_count <= 0;
			want_q.delete();
		end else begin
			if (valid) begin
				if (want_q.size() == 0) begin
					$display("%0t: unexpected beat status=%0d start=%h finish=%h",
						$time, status, start_res, finish);
					fail_count <= fail_count + 1;
				end else begin
					w = want_q.pop_front();
					if (w.st !== status || w.s !== start_res || w.e !== finish ||
							w.n !== entries || w.l !== last) begin
						$display("%0t: expected st=%0d s=%h e=%h n=%0d l=%0d, ",
							$time, w.st, w.s, w.e, w.n, w.l,
							"got st=%0d s=%h e=%h n=%0d l=%0d",
							status, start_res, finish, entries, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) predict_cmd(cmd, lo, hi);
		end
	end
endmodule

>>> test/tb_interval_merge_set.sv
module tb_interval_merge_set;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n, start, busy, cmd, valid, last;
	logic [31:0] lo, hi, start_res, finish;
	logic [2:0]  status;
	logic [5:0]  entries;
	int          fail_count, pending, cycles;

	interval_merge_set u_top (.*);

	ims_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send(input logic c, input logic [31:0] a, input logic [31:0] z);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1; cmd <= c; lo <= a; hi <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	initial begin
		logic [31:0] a, w;
		int k, mode;
		arst_n = 1'b0; start = 1'b0; cmd = 1'b0; lo = '0; hi = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(ims_pkg::CMD_LIST, 32'hFFFF_FFFF, 0);
		send(ims_pkg::CMD_ADD, 5, 5);
		send(ims_pkg::CMD_ADD, 9, 3);
		send(ims_pkg::CMD_ADD, 0, 32'hFFFF_FFFF);
		send(ims_pkg::CMD_LIST, 0, 0);
		send(ims_pkg::CMD_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send(ims_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
		arst_n <= 1'b1;
		// fill with disjoint, non-touching intervals, then overflow
		for (k = 0; k < 34; k++) send(ims_pkg::CMD_ADD, 1000 + 10 * k, 1005 + 10 * k);
		send(ims_pkg::CMD_LIST, 0, 0);
		send(ims_pkg::CMD_ADD, 1005, 1010);
		send(ims_pkg::CMD_ADD, 1000, 1005);
		send(ims_pkg::CMD_ADD, 1, 2000);
		send(ims_pkg::CMD_LIST, 0, 0);
		drain();
		for (k = 0; k < 155; k++) begin
			mode = $urandom_range(0, 9);
			if (mode == 0) send(ims_pkg::CMD_LIST, $urandom, $urandom);
			else if (mode == 1) send(ims_pkg::CMD_ADD, $urandom, $urandom);
			else begin
				a = $urandom_range(0, 3000);
				w = $urandom_range(1, 40);
				if ($urandom_range(0, 9) == 0) a = 32'hFFFF_FFFF - $urandom_range(0, 2000);
				if ($urandom_range(0, 15) == 0) w = 0;
				send(ims_pkg::CMD_ADD, a, (a + w < a) ? 32'hFFFF_FFFF : a + w);
			end
			if (k == 75) drain();
		end
		send(ims_pkg::CMD_LIST, 0, 0);
		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
